// ----- rtl/core/bis_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CFG_W = 9;
	localparam int VAL_W = 32;
	localparam int GUESS_W = 16;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [7:0] entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] target;
		logic [15:0] start_guess;
	} in_word_t;

	typedef struct packed {
		logic found;
		logic [7:0] bin_index;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_RDL,
		ST_CHK,
		ST_DONE
	} bis_state_t;

	typedef struct packed {
		logic write;
		logic start;
		logic eval;
		logic rd_last;
		logic check;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic single;
		logic hit;
		logic last_iter;
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/bis_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

// ----- rtl/core/bis_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bis_ctrl import bis_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       req_type,
	output logic            in_stall,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	bis_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (req_type == REQ_WRITE) begin
						cmd.write = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d = status.single ? ST_RDL : ST_RD;
					end
				end
			end
			ST_RD: begin
				state_d = ST_EV;
			end
			ST_EV: begin
				cmd.eval = 1'b1;
				if (status.hit) begin
					state_d = ST_DONE;
				end else if (status.last_iter) begin
					state_d = ST_RDL;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_RDL: begin
				cmd.rd_last = 1'b1;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				cmd.check = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!status.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/bis_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bis_dpath import bis_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ctrl_cmd_t        cmd,
	input  wire in_word_t         in_word,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output out_word_t             out_word,
	output dp_status_t            status
);

	localparam logic [CFG_W-1:0] N_MAX = CFG_W'(TABLE_DEPTH);

	logic [CFG_W-1:0] pu_q;
	logic [CFG_W-1:0] n;
	logic [CFG_W-1:0] n_m2;
	logic [IDX_W-1:0] last_idx;

	logic signed [VAL_W-1:0] t_q;
	logic [IDX_W-1:0] ndx_q;
	logic [IDX_W-1:0] ndx_next;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] best_q;
	logic [IDX_W-1:0] cand_q;
	logic [VAL_W-1:0] dx_q;
	logic [VAL_W-1:0] del_q;
	logic pend_q;
	logic first_q;
	logic down_q;
	logic single_q;

	logic res_found_q;
	logic [IDX_W-1:0] res_bin_q;
	logic out_valid_q;
	out_word_t out_word_q;

	logic [IDX_W-1:0] raddr_a;
	logic [IDX_W-1:0] raddr_b;
	logic [VAL_W-1:0] rdata_a;
	logic [VAL_W-1:0] rdata_b;
	logic signed [VAL_W-1:0] xa;
	logic signed [VAL_W-1:0] xb;

	logic hit;
	logic down_now;
	logic dir_down;
	logic [VAL_W:0] diff;
	logic [VAL_W:0] absd;
	logic guess_bad;
	logic single_now;

	// Effective number of points: zero acts as one, large values clamp to the table size.
	always_comb begin
		if (pu_q == '0) begin
			n = CFG_W'(1);
		end else if (pu_q > N_MAX) begin
			n = N_MAX;
		end else begin
			n = pu_q;
		end
	end

	assign n_m2 = n - CFG_W'(2);
	assign last_idx = IDX_W'(n - CFG_W'(1));
	assign single_now = (n < CFG_W'(2));
	assign guess_bad = ({{(GUESS_W - CFG_W){1'b0}}, n_m2} < in_word.start_guess);

	assign raddr_a = cmd.rd_last ? (single_q ? '0 : last_idx) : ndx_q;
	assign raddr_b = ndx_q + IDX_W'(1);

	bis_ram #(
		.WIDTH(VAL_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(cmd.write),
		.waddr(in_word.entry_index),
		.wdata(in_word.entry_value),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	assign xa = rdata_a;
	assign xb = rdata_b;

	always_comb begin
		if (xa < xb) begin
			hit = (t_q >= xa) && (t_q < xb);
		end else if (xa > xb) begin
			hit = (t_q > xb) && (t_q <= xa);
		end else begin
			hit = 1'b0;
		end
	end

	assign down_now = (xa != xb) && (t_q != xa) && ((t_q < xa) != (xb < xa));
	assign dir_down = first_q ? down_now : down_q;

	assign diff = {t_q[VAL_W-1], t_q} - {xa[VAL_W-1], xa};
	assign absd = diff[VAL_W] ? ((VAL_W + 1)'(0) - diff) : diff;

	always_comb begin
		if (dir_down) begin
			ndx_next = (ndx_q == '0) ? IDX_W'(n_m2) : ndx_q - IDX_W'(1);
		end else begin
			ndx_next = ({1'b0, ndx_q} >= n_m2) ? '0 : ndx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pu_q <= N_MAX;
		end else if (cfg_we) begin
			pu_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.eval && !hit) begin
				pend_q <= 1'b1;
			end else begin
				pend_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			t_q <= in_word.target;
			ndx_q <= guess_bad ? '0 : in_word.start_guess[IDX_W-1:0];
			best_q <= guess_bad ? '0 : in_word.start_guess[IDX_W-1:0];
			dx_q <= '1;
			k_q <= '0;
			first_q <= 1'b1;
			single_q <= single_now;
		end else begin
			if (cmd.eval) begin
				del_q <= absd[VAL_W-1:0];
				cand_q <= ndx_q;
				first_q <= 1'b0;
				down_q <= dir_down;
				if (hit) begin
					res_found_q <= 1'b1;
					res_bin_q <= ndx_q;
				end else begin
					ndx_q <= ndx_next;
					k_q <= k_q + IDX_W'(1);
				end
			end
			if (pend_q && (del_q < dx_q)) begin
				dx_q <= del_q;
				best_q <= cand_q;
			end
		end
		if (cmd.check) begin
			if (single_q) begin
				res_found_q <= (t_q == xa);
				res_bin_q <= '0;
			end else if (t_q == xa) begin
				res_found_q <= 1'b1;
				res_bin_q <= IDX_W'(n_m2);
			end else begin
				res_found_q <= 1'b0;
				res_bin_q <= best_q;
			end
		end
		if (cmd.load_out) begin
			out_word_q.found <= res_found_q;
			out_word_q.bin_index <= res_bin_q;
		end
	end

	assign status.single = single_now;
	assign status.hit = hit;
	assign status.last_iter = (k_q == last_idx);
	assign status.out_busy = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

endmodule

`default_nettype wire

// ----- rtl/core/bracket_interval_search.sv -----
// Bracketing interval search over a table of up to 256 signed Q16.16 abscissas.
// Input words arrive on in_valid/in_stall/in_data. A write word (req_type 0)
// stores entry_value in slot entry_index and leaves the block idle; it gives
// no result. A search word (req_type 1) walks the table from start_guess and
// returns one result word on out_valid/out_stall/out_data: found and bin_index.
// The table has one RAM with two read ports, so each bin tried takes a read
// state (ST_RD, address) and then an evaluate state (ST_EV, compare). A hit
// goes straight to ST_DONE; a miss then reads and compares the last point
// (ST_RDL, ST_CHK). A table of one point goes through ST_RDL and ST_CHK only.
// One search runs at a time; in_stall is high while it runs. Write words and
// a new search are taken while the previous result word still waits.
// If the receiver stalls, the result word holds and a finished search waits
// for the output register to free up.
// The points_in_use register is written through cfg_we/cfg_wdata; the user
// writes it only while idle; the block does not enforce this. Reset clears
// control state, sets points_in_use to 256; table is undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module bracket_interval_search import bis_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_word_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_word_t             out_data,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	ctrl_cmd_t cmd;
	dp_status_t status;

	bis_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.req_type(in_data.req_type),
		.in_stall(in_stall),
		.status(status),
		.cmd(cmd)
	);

	bis_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.in_word(in_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_word(out_data),
		.status(status)
	);

endmodule

`default_nettype wire

// ----- sim/tb_bracket_interval_search.sv -----
`timescale 1ns / 1ps

module tb_bracket_interval_search;
	import bis_pkg::*;

	typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [CFG_W-1:0] points;
		in_word_t word;
		bit fixed;
		out_word_t want;
	} dir_row_t;

	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 64;
	localparam int CFG_SETTLE = 8;
	localparam int RANDOM_ITEMS = 1570;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	logic signed [VAL_W-1:0] abscissa [TABLE_DEPTH];
	logic [CFG_W-1:0] points_cfg = 9'd256;
	out_word_t expected_bins [$];
	dir_row_t dir_rows [$];
	int mismatches = 0;
	int random_items = 0;
	bit calm = 1'b0;

	bracket_interval_search u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int points_eff();
		int n;
		n = int'(points_cfg);
		if (n < 1) n = 1;
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		return n;
	endfunction

	function automatic out_word_t bracket_lookup(input logic signed [VAL_W-1:0] tgt,
			input logic [GUESS_W-1:0] guess);
		longint t, a, b, dx, del, num, den;
		int n, ndx, best, stp;
		bit hit;
		out_word_t r;
		t = tgt;
		n = points_eff();
		hit = 1'b0;
		if (n < 2) begin
			r.found = (abscissa[0] == tgt);
			r.bin_index = '0;
			return r;
		end
		ndx = int'(guess);
		if (ndx > n - 2) ndx = 0;
		best = ndx;
		a = abscissa[ndx];
		b = abscissa[ndx + 1];
		dx = (t > a) ? t - a : a - t;
		num = t - a;
		den = b - a;
		stp = (den != 0 && num != 0 && ((num < 0) != (den < 0))) ? -1 : 1;
		for (int k = 0; k < n; k++) begin
			if (ndx > n - 2 && stp > 0) ndx = 0;
			if (ndx < 0) ndx = 0;
			a = abscissa[ndx];
			b = abscissa[ndx + 1];
			if ((a < b && t >= a && t < b) || (a > b && t > b && t <= a)) begin
				hit = 1'b1;
				break;
			end
			del = (t > a) ? t - a : a - t;
			if (del < dx) begin
				dx = del;
				best = ndx;
			end
			if (ndx <= 0 && stp < 0) ndx = n - 1;
			ndx += stp;
		end
		if (hit) begin
			r.found = 1'b1;
			r.bin_index = 8'(ndx);
		end else if (t == longint'(abscissa[n - 1])) begin
			r.found = 1'b1;
			r.bin_index = 8'(n - 2);
		end else begin
			r.found = 1'b0;
			r.bin_index = 8'(best);
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatches < 100) $display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	function automatic in_word_t rand_word(input logic req);
		in_word_t w;
		w.req_type = req;
		w.entry_index = 8'($urandom);
		w.entry_value = $urandom;
		w.target = $urandom;
		w.start_guess = 16'($urandom);
		return w;
	endfunction

	function automatic void add_search(input logic signed [VAL_W-1:0] tgt, input int guess,
			input bit fixed, input bit f, input int bin);
		dir_row_t row;
		row.kind = ROW_ITEM;
		row.points = '0;
		row.word = '0;
		row.word.req_type = REQ_SEARCH;
		row.word.target = tgt;
		row.word.start_guess = 16'(guess);
		row.fixed = fixed;
		row.want.found = f;
		row.want.bin_index = 8'(bin);
		dir_rows.push_back(row);
	endfunction

	function automatic void add_write(input int idx, input logic signed [VAL_W-1:0] val);
		dir_row_t row;
		row.kind = ROW_ITEM;
		row.points = '0;
		row.word = '0;
		row.word.req_type = REQ_WRITE;
		row.word.entry_index = 8'(idx);
		row.word.entry_value = val;
		row.fixed = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_cfg(input int v);
		dir_row_t row;
		row.kind = ROW_CFG;
		row.points = 9'(v);
		row.word = '0;
		row.fixed = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endfunction

	task automatic drive_word(input in_word_t w, input bit fixed, input out_word_t want);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (w.req_type == REQ_WRITE) begin
			abscissa[w.entry_index] = w.entry_value;
		end else begin
			expected_bins.push_back(fixed ? want : bracket_lookup(w.target, w.start_guess));
		end
	endtask

	task automatic write_points(input logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (expected_bins.size() != 0) @(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		points_cfg = v;
	endtask

	function automatic logic signed [VAL_W-1:0] pick_target(input int n);
		int j;
		longint a, b;
		j = $urandom_range(0, n - 1);
		a = abscissa[j];
		b = (j + 1 < n) ? abscissa[j + 1] : a;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'(a);
			4: return 32'(a + 1);
			5: return 32'(a - 1);
			6, 7: return 32'((a + b) / 2);
			8: return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
			default: return $urandom;
		endcase
	endfunction

	// Most tables are monotonic so that searches get past the first bin; steps of zero give
	// flat bins, and saturation piles points up at the ends of the range.
	task automatic rebuild_table(input int n);
		in_word_t w;
		longint v, stepmax, stp;
		int style;
		style = $urandom_range(0, 9);
		case ($urandom_range(0, 3))
			0: stepmax = 3;
			1: stepmax = 65536;
			2: stepmax = 64'sd1 << 24;
			default: stepmax = 64'd4294967295 / n;
		endcase
		v = int'($urandom);
		if ($urandom_range(0, 3) == 0) v = (style < 4) ? VAL_MIN : VAL_MAX;
		for (int i = 0; i < n; i++) begin
			w = rand_word(REQ_WRITE);
			w.entry_index = 8'(i);
			w.entry_value = 32'(v);
			drive_word(w, 1'b0, '0);
			random_items++;
			stp = $urandom_range(0, 32'(stepmax));
			if (style < 4) begin
				v += stp;
				if (v > VAL_MAX) v = VAL_MAX;
			end else if (style < 7) begin
				v -= stp;
				if (v < VAL_MIN) v = VAL_MIN;
			end else begin
				v = int'($urandom);
			end
		end
	endtask

	initial begin
		in_word_t w;
		int n, batch;
		logic [CFG_W-1:0] pts;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every slot is written before the first search, so no search reads an unwritten entry.
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			w = rand_word(REQ_WRITE);
			w.entry_index = 8'(i);
			w.entry_value = 32'((i - 128) * 65536);
			drive_word(w, 1'b0, '0);
		end

		add_search(0, 0, 1, 1, 128);
		add_search(0, 16'hFFFF, 1, 1, 128);
		add_search(VAL_MIN, 200, 1, 0, 0);
		add_search(VAL_MAX, 0, 1, 0, 254);
		add_search(127 * 65536, 10, 1, 1, 254);
		add_search(-128 * 65536, 0, 1, 1, 0);
		add_search(5 * 65536 + 1, 254, 1, 1, 133);
		add_search(-3 * 65536, 140, 0, 0, 0);
		add_cfg(2);
		add_write(0, VAL_MAX);
		add_write(1, VAL_MIN);
		add_search(0, 0, 1, 1, 0);
		add_search(VAL_MIN, 1, 1, 1, 0);
		add_search(VAL_MAX, 0, 1, 1, 0);
		add_write(1, VAL_MAX);
		add_search(VAL_MAX, 0, 1, 1, 0);
		add_search(5, 0, 1, 0, 0);
		add_cfg(1);
		add_search(VAL_MAX, 0, 1, 1, 0);
		add_search(0, 0, 1, 0, 0);
		add_cfg(0);
		add_search(VAL_MAX, 3, 1, 1, 0);
		add_cfg(511);
		add_write(255, VAL_MIN);
		add_search(0, 7, 0, 0, 0);
		add_search(VAL_MIN, 16'hFFFF, 0, 0, 0);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				write_points(dir_rows[r].points);
			end else begin
				drive_word(dir_rows[r].word, dir_rows[r].fixed, dir_rows[r].want);
			end
		end

		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 15))
				0: pts = ($urandom_range(0, 1) != 0) ? 9'd256 : 9'($urandom_range(257, 511));
				1: pts = 9'($urandom_range(0, 1));
				2: pts = 9'($urandom_range(25, 100));
				default: pts = 9'($urandom_range(2, 24));
			endcase
			write_points(pts);
			calm = ($urandom_range(0, 3) == 0);
			n = points_eff();
			if ($urandom_range(0, 9) != 0) rebuild_table(n);
			batch = (n > 64) ? $urandom_range(4, 10) : $urandom_range(10, 40);
			repeat (batch) begin
				if ($urandom_range(0, 7) == 0) begin
					w = rand_word(REQ_WRITE);
					if ($urandom_range(0, 1) != 0) w.entry_index = 8'($urandom_range(0, n - 1));
				end else begin
					w = rand_word(REQ_SEARCH);
					w.target = pick_target(n);
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: w.start_guess = 16'($urandom_range(0, (n > 1) ? n - 2 : 0));
						6, 7: w.start_guess = 16'($urandom);
						8: w.start_guess = 16'hFFFF;
						default: w.start_guess = 16'(n - 1);
					endcase
				end
				drive_word(w, 1'b0, '0);
				random_items++;
			end
		end

		in_valid <= 1'b0;
		while (expected_bins.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_bins.size() == 0) begin
			$display("bracket_interval_search test passed");
		end else begin
			$display("bracket_interval_search test failed");
		end
		$finish;
	end

	initial begin
		out_word_t want;
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 7);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			if (expected_bins.size() == 0) begin
				flag_mismatch("result word with no search pending");
			end else begin
				want = expected_bins.pop_front();
				if (out_data.found !== want.found)
					flag_mismatch($sformatf("found %b, expected %b", out_data.found, want.found));
				if (out_data.bin_index !== want.bin_index)
					flag_mismatch($sformatf("bin_index %0d, expected %0d",
						out_data.bin_index, want.bin_index));
			end
		end
	end

	initial begin
		#50_000_000;
		$display("bracket_interval_search test failed");
		$finish;
	end

endmodule
